@@ rtl/core/cdd_pkg.sv @@
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared types and constants for the complex dimension decoder: request and
// result payloads, configuration bundle, pipeline stage bundles and codes.
// ----------------------------------------------------------------------------
package cdd_pkg;

   // fixed point position of the pixel and fraction results
   localparam int FRAC_BITS = 16;

   // field widths
   localparam int WORD_W  = 32;
   localparam int BASE_W  = 32;
   localparam int VAL_W   = 56;
   localparam int SIZE_W  = 32;
   localparam int MAG_W   = 24;
   localparam int DENS_W  = 24;
   localparam int DPI_W   = 28;
   localparam int F1_W    = 28;
   localparam int F2_W    = 20;
   localparam int T_W     = MAG_W + F1_W;
   localparam int P_W     = T_W + F2_W;
   localparam int PF_W    = MAG_W + BASE_W;
   localparam int SH_W    = 8;
   localparam int Q_W     = VAL_W + 1;

   // apb port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // fraction bits of the factors
   localparam int DENS_FRAC = 16;
   localparam int BASE_FRAC = 16;
   localparam int K_FRAC    = 24;

   // 2^24/72 and 2^24/25.4 rounded to unsigned q0.24
   localparam logic [F2_W-1:0] K72  = F2_W'(233017);
   localparam logic [F2_W-1:0] K254 = F2_W'(660520);

   // register reset values
   localparam logic [DENS_W-1:0] DENSITY_RST        = DENS_W'(65536);
   localparam logic [DENS_W-1:0] FONT_DENSITY_RST   = DENS_W'(65536);
   localparam logic [DPI_W-1:0]  HORIZONTAL_DPI_RST = DPI_W'(10485760);

   // unit codes
   typedef enum logic [3:0] {
      UNIT_PX  = 4'd0,
      UNIT_DIP = 4'd1,
      UNIT_SP  = 4'd2,
      UNIT_PT  = 4'd3,
      UNIT_IN  = 4'd4,
      UNIT_MM  = 4'd5
   } unit_type;

   // register indexes
   typedef enum logic [1:0] {
      CSR_DENSITY        = 2'd0,
      CSR_FONT_DENSITY   = 2'd1,
      CSR_HORIZONTAL_DPI = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0]        complex_word;
      logic signed [BASE_W-1:0] fraction_base;
      logic signed [BASE_W-1:0] parent_base;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]  pixel_value;
      logic signed [SIZE_W-1:0] pixel_size;
      logic signed [VAL_W-1:0]  fraction_value;
   } rsp_type;

   typedef struct packed {
      logic [DENS_W-1:0] density;
      logic [DENS_W-1:0] font_density;
      logic [DPI_W-1:0]  horizontal_dpi;
   } cfg_type;

   // decoded word, ready for the multipliers
   typedef struct packed {
      logic                   neg;
      logic [MAG_W-1:0]       mag;
      logic [F1_W-1:0]        f1;
      logic [F2_W-1:0]        f2;
      logic signed [SH_W-1:0] n_val;
      logic signed [SH_W-1:0] n_size;
      logic                   fneg;
      logic [BASE_W-1:0]      fm;
      logic signed [SH_W-1:0] n_frac;
   } dec_type;

   // exact magnitudes with their shift counts
   typedef struct packed {
      logic                   neg;
      logic                   fneg;
      logic [P_W-1:0]         p;
      logic [PF_W-1:0]        pf;
      logic signed [SH_W-1:0] n_val;
      logic signed [SH_W-1:0] n_size;
      logic signed [SH_W-1:0] n_frac;
   } prod_type;

endpackage

@@ rtl/core/cdd_csr.sv @@
// ----------------------------------------------------------------------------
// cdd_csr
// APB register file holding density, font density and horizontal dpi.
// ----------------------------------------------------------------------------
module cdd_csr import cdd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [DENS_W-1:0] density_ff, density_in;
   logic [DENS_W-1:0] font_density_ff, font_density_in;
   logic [DPI_W-1:0]  horizontal_dpi_ff, horizontal_dpi_in;
   logic              wr_en;
   csr_index_type     index;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign index  = csr_index_type'(paddr[3:2]);

   // write decode
   always_comb begin
      density_in        = density_ff;
      font_density_in   = font_density_ff;
      horizontal_dpi_in = horizontal_dpi_ff;
      if (wr_en) begin
         unique case (index)
            CSR_DENSITY:        density_in        = pwdata[DENS_W-1:0];
            CSR_FONT_DENSITY:   font_density_in   = pwdata[DENS_W-1:0];
            CSR_HORIZONTAL_DPI: horizontal_dpi_in = pwdata[DPI_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff        <= DENSITY_RST;
         font_density_ff   <= FONT_DENSITY_RST;
         horizontal_dpi_ff <= HORIZONTAL_DPI_RST;
      end else begin
         density_ff        <= density_in;
         font_density_ff   <= font_density_in;
         horizontal_dpi_ff <= horizontal_dpi_in;
      end
   end

   // read mux
   always_comb begin
      unique case (index)
         CSR_DENSITY:        prdata = CSR_DATA_W'(density_ff);
         CSR_FONT_DENSITY:   prdata = CSR_DATA_W'(font_density_ff);
         CSR_HORIZONTAL_DPI: prdata = CSR_DATA_W'(horizontal_dpi_ff);
         default:            prdata = '0;
      endcase
   end

   assign cfg.density        = density_ff;
   assign cfg.font_density   = font_density_ff;
   assign cfg.horizontal_dpi = horizontal_dpi_ff;

endmodule

@@ rtl/core/cdd_decode.sv @@
// ----------------------------------------------------------------------------
// cdd_decode
// Input stage: unpacks the complex word into sign and magnitude, picks the
// unit factors and base, and works out the rounding shift of each result.
// ----------------------------------------------------------------------------
module cdd_decode import cdd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output dec_type out_data
);

   logic             valid_ff, valid_in;
   dec_type          data_ff, data_in;
   logic             en;
   logic [3:0]       unit;
   logic [MAG_W-1:0] raw;
   logic [4:0]       s;
   logic [5:0]       fb;
   logic [4:0]       ffb;
   logic [BASE_W-1:0] b;
   logic [SH_W-1:0]  n_size_w;

   // radix to binary point position of the mantissa
   function automatic logic [4:0] radix_shift(input logic [1:0] radix);
      logic [4:0] r;
      case (radix)
         2'd0:    r = 5'd0;
         2'd1:    r = 5'd7;
         2'd2:    r = 5'd15;
         default: r = 5'd23;
      endcase
      return r;
   endfunction

   assign en       = ~valid_ff | out_ready;
   assign in_ready = en;
   assign valid_in = en ? in_valid : valid_ff;

   always_comb begin
      unit = in_data.complex_word[3:0];
      raw  = in_data.complex_word[WORD_W-1:8];
      s    = radix_shift(in_data.complex_word[5:4]);

      data_in.neg = raw[MAG_W-1];
      data_in.mag = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;

      // pixel factors by unit, unknown units as px
      data_in.f1 = F1_W'(1);
      data_in.f2 = F2_W'(1);
      fb         = 6'd0;
      unique case (unit_type'(unit))
         UNIT_DIP: begin
            data_in.f1 = F1_W'(cfg.density);
            fb         = 6'(DENS_FRAC);
         end
         UNIT_SP: begin
            data_in.f1 = F1_W'(cfg.font_density);
            fb         = 6'(DENS_FRAC);
         end
         UNIT_PT: begin
            data_in.f1 = cfg.horizontal_dpi;
            data_in.f2 = K72;
            fb         = 6'(DENS_FRAC + K_FRAC);
         end
         UNIT_IN: begin
            data_in.f1 = cfg.horizontal_dpi;
            fb         = 6'(DENS_FRAC);
         end
         UNIT_MM: begin
            data_in.f1 = cfg.horizontal_dpi;
            data_in.f2 = K254;
            fb         = 6'(DENS_FRAC + K_FRAC);
         end
         default: ;
      endcase

      n_size_w       = SH_W'(s) + SH_W'(fb);
      data_in.n_size = $signed(n_size_w);
      data_in.n_val  = $signed(n_size_w - SH_W'(FRAC_BITS));

      // fraction base: px takes the base, dip the parent base
      b            = $unsigned(in_data.fraction_base);
      data_in.fm   = BASE_W'(1);
      data_in.fneg = raw[MAG_W-1];
      ffb          = 5'd0;
      if (unit == UNIT_PX || unit == UNIT_DIP) begin
         if (unit == UNIT_DIP) begin
            b = $unsigned(in_data.parent_base);
         end
         data_in.fm   = b[BASE_W-1] ? (BASE_W'(0) - b) : b;
         data_in.fneg = raw[MAG_W-1] ^ b[BASE_W-1];
         ffb          = 5'(BASE_FRAC);
      end
      data_in.n_frac = $signed(SH_W'(s) + SH_W'(ffb) - SH_W'(FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/core/cdd_mult.sv @@
// ----------------------------------------------------------------------------
// cdd_mult
// Three-stage exact product: magnitude times first factor and times base,
// then the second factor in two partial products, then their sum.
// ----------------------------------------------------------------------------
module cdd_mult import cdd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  dec_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output prod_type out_data
);

   localparam int PL_W = 32 + F2_W;
   localparam int PH_W = (T_W - 32) + F2_W;

   // stage valids and enables
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic en1, en2, en3;

   // side data carried along
   logic                   neg1_ff, fneg1_ff, neg2_ff, fneg2_ff;
   logic signed [SH_W-1:0] nv1_ff, ns1_ff, nf1_ff, nv2_ff, ns2_ff, nf2_ff;
   logic [F2_W-1:0]        f2_1_ff;

   // products
   logic [T_W-1:0]  t_ff, t_in;
   logic [PF_W-1:0] pf1_ff, pf1_in, pf2_ff;
   logic [PL_W-1:0] pl_ff, pl_in;
   logic [PH_W-1:0] ph_ff, ph_in;
   prod_type        out_ff, out_in;

   assign en3      = ~v3_ff | out_ready;
   assign en2      = ~v2_ff | en3;
   assign en1      = ~v1_ff | en2;
   assign in_ready = en1;

   assign v1_in = en1 ? in_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // first products
   assign t_in  = T_W'(in_data.mag) * T_W'(in_data.f1);
   assign pf1_in = PF_W'(in_data.mag) * PF_W'(in_data.fm);

   always_ff @(posedge clock) begin
      if (en1) begin
         t_ff     <= t_in;
         pf1_ff   <= pf1_in;
         f2_1_ff  <= in_data.f2;
         neg1_ff  <= in_data.neg;
         fneg1_ff <= in_data.fneg;
         nv1_ff   <= in_data.n_val;
         ns1_ff   <= in_data.n_size;
         nf1_ff   <= in_data.n_frac;
      end
   end

   // second factor split over the low and high halves
   assign pl_in = PL_W'(t_ff[31:0]) * PL_W'(f2_1_ff);
   assign ph_in = PH_W'(t_ff[T_W-1:32]) * PH_W'(f2_1_ff);

   always_ff @(posedge clock) begin
      if (en2) begin
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
         pf2_ff   <= pf1_ff;
         neg2_ff  <= neg1_ff;
         fneg2_ff <= fneg1_ff;
         nv2_ff   <= nv1_ff;
         ns2_ff   <= ns1_ff;
         nf2_ff   <= nf1_ff;
      end
   end

   // partial product sum
   always_comb begin
      out_in.p      = (P_W'(ph_ff) << 32) + P_W'(pl_ff);
      out_in.pf     = pf2_ff;
      out_in.neg    = neg2_ff;
      out_in.fneg   = fneg2_ff;
      out_in.n_val  = nv2_ff;
      out_in.n_size = ns2_ff;
      out_in.n_frac = nf2_ff;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = out_ff;

endmodule

@@ rtl/core/cdd_round.sv @@
// ----------------------------------------------------------------------------
// cdd_round
// Three-stage rounding: shift each exact product to its binary point,
// add the round bit, then saturate and apply the sign. Last stage is the
// result register.
// ----------------------------------------------------------------------------
module cdd_round import cdd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  prod_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   localparam logic [Q_W-1:0] MAG_CAP  = Q_W'(1) << VAL_W;
   localparam logic [Q_W-1:0] VAL_LIM  = Q_W'(1) << (VAL_W - 1);
   localparam logic [Q_W-1:0] SIZE_LIM = Q_W'(1) << (SIZE_W - 1);

   typedef struct packed {
      logic [Q_W-1:0] q;
      logic           rb;
   } split_type;

   // truncated magnitude and round bit of p / 2^n, capped at 2^56
   function automatic split_type scale_split(input logic [P_W-1:0] p,
                                             input logic signed [SH_W-1:0] n);
      logic [P_W+FRAC_BITS-1:0] lsh;
      logic [P_W-1:0]           rsh;
      logic [SH_W-1:0]          amt;
      logic                     over;
      split_type                r;
      if (n[SH_W-1] || n == '0) begin
         amt  = SH_W'(0) - $unsigned(n);
         lsh  = {{FRAC_BITS{1'b0}}, p} << amt;
         over = |lsh[P_W+FRAC_BITS-1:VAL_W];
         r.q  = over ? MAG_CAP : {1'b0, lsh[VAL_W-1:0]};
         r.rb = 1'b0;
      end else begin
         amt  = $unsigned(n) - SH_W'(1);
         rsh  = p >> amt;
         over = |rsh[P_W-1:VAL_W+1];
         r.q  = over ? MAG_CAP : {1'b0, rsh[VAL_W:1]};
         r.rb = ~over & rsh[0];
      end
      return r;
   endfunction

   // sign and magnitude to a saturated two's complement field
   function automatic logic [VAL_W-1:0] sat_value(input logic neg,
                                                  input logic [Q_W-1:0] m);
      logic [Q_W-1:0] sat;
      if (neg) begin
         sat = (m > VAL_LIM) ? VAL_LIM : m;
         return VAL_W'(Q_W'(0) - sat);
      end
      sat = (m > VAL_LIM - Q_W'(1)) ? (VAL_LIM - Q_W'(1)) : m;
      return sat[VAL_W-1:0];
   endfunction

   function automatic logic [SIZE_W-1:0] sat_size(input logic neg,
                                                  input logic [Q_W-1:0] m);
      logic [Q_W-1:0] sat;
      if (neg) begin
         sat = (m > SIZE_LIM) ? SIZE_LIM : m;
         return SIZE_W'(Q_W'(0) - sat);
      end
      sat = (m > SIZE_LIM - Q_W'(1)) ? (SIZE_LIM - Q_W'(1)) : m;
      return sat[SIZE_W-1:0];
   endfunction

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic en1, en2, en3;

   split_type      sv1_ff, ss1_ff, sf1_ff;
   logic           neg1_ff, fneg1_ff, pnz1_ff;
   logic [Q_W-1:0] mv2_ff, ms2_ff, mf2_ff, ms_fix;
   logic           neg2_ff, fneg2_ff, pnz2_ff;
   rsp_type        out_ff, out_in;

   assign en3      = ~v3_ff | out_ready;
   assign en2      = ~v2_ff | en3;
   assign en1      = ~v1_ff | en2;
   assign in_ready = en1;

   assign v1_in = en1 ? in_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // shift to the binary point
   always_ff @(posedge clock) begin
      if (en1) begin
         sv1_ff   <= scale_split(in_data.p, in_data.n_val);
         ss1_ff   <= scale_split(in_data.p, in_data.n_size);
         sf1_ff   <= scale_split(P_W'(in_data.pf), in_data.n_frac);
         neg1_ff  <= in_data.neg;
         fneg1_ff <= in_data.fneg;
         pnz1_ff  <= |in_data.p;
      end
   end

   // round half up on the magnitude
   always_ff @(posedge clock) begin
      if (en2) begin
         mv2_ff   <= sv1_ff.q + Q_W'(sv1_ff.rb);
         ms2_ff   <= ss1_ff.q + Q_W'(ss1_ff.rb);
         mf2_ff   <= sf1_ff.q + Q_W'(sf1_ff.rb);
         neg2_ff  <= neg1_ff;
         fneg2_ff <= fneg1_ff;
         pnz2_ff  <= pnz1_ff;
      end
   end

   // a nonzero size never rounds to zero, then saturate and sign
   always_comb begin
      ms_fix                = (ms2_ff == '0 && pnz2_ff) ? Q_W'(1) : ms2_ff;
      out_in.pixel_value    = $signed(sat_value(neg2_ff, mv2_ff));
      out_in.pixel_size     = $signed(sat_size(neg2_ff, ms_fix));
      out_in.fraction_value = $signed(sat_value(fneg2_ff, mf2_ff));
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = out_ff;

endmodule

@@ rtl/core/complex_dimension_decode.sv @@
// ----------------------------------------------------------------------------
// complex_dimension_decode
// Decodes a packed complex dimension word into pixel value, pixel size and
// fraction value.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result side keeps up. A request passes
// through one input stage (decode), three multiplier stages (the 72-bit exact
// product is built from partial products no wider than 32x28) and three rounding
// stages, the last of which is the result register. Every stage holds its own
// valid bit, so bubbles close up and req_ready falls only when the pipeline is
// full behind a stalled result. The user must write the registers through the apb
// port only while no request is in flight; the block does not enforce this.
// density, font_density and horizontal_dpi sit at byte offsets 0x0, 0x4 and 0x8.
module complex_dimension_decode import cdd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type  cfg;
   dec_type  dec_data;
   prod_type prod_data;
   logic     dec_valid, dec_ready, prod_valid, prod_ready;

   // configuration registers
   cdd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // unpack and select factors
   cdd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   // exact products
   cdd_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   // round, saturate and register the result
   cdd_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // input backs up only behind a stalled result
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled while the result side is free");

   // with the result side open an accepted request comes out as a valid result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result missing after pipeline latency");

   // a zero size means a zero product, so the pixel value is zero too
   a_zero_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pixel_size == '0) |-> (rsp_data.pixel_value == '0))
      else $error("zero pixel size with nonzero pixel value");

   // pixel value and pixel size share their sign
   a_sign_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pixel_value != '0)
      |-> (rsp_data.pixel_value[VAL_W-1] == rsp_data.pixel_size[SIZE_W-1]))
      else $error("pixel value and pixel size differ in sign");

endmodule
